FILE: sv/lfbd_pkg.sv
package lfbd_pkg;

   // Register port address width: three 32-bit registers at byte addresses 0, 4, 8
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // Register reset values
   localparam logic [7:0]  START_BYTE_RST    = 8'd126;
   localparam logic [7:0]  END_BYTE_RST      = 8'd127;
   localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

   // Idle timer saturates at all ones
   localparam logic [15:0] TIMER_MAX = 16'hFFFF;

   // Input operation codes
   typedef enum logic [1:0] {
      OP_BYTE   = 2'd0,
      OP_TICK   = 2'd1,
      OP_STATUS = 2'd2,
      OP_RESET  = 2'd3
   } op_type;

   // Parser phases
   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LEN  = 2'd1,
      PH_DATA = 2'd2,
      PH_END  = 2'd3
   } phase_type;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_NONE    = 3'd0,
      KIND_PAYLOAD = 3'd1,
      KIND_GOOD    = 3'd2,
      KIND_BADEND  = 3'd3,
      KIND_TIMEOUT = 3'd4,
      KIND_STATUS  = 3'd5
   } kind_type;

   // Configuration seen by the parser
   typedef struct packed {
      logic [7:0]  start_byte;
      logic [7:0]  end_byte;
      logic [15:0] timeout_ticks;
   } cfg_type;

   // Parser state
   typedef struct packed {
      phase_type   phase;
      logic [7:0]  remaining;
      logic [7:0]  position;
      logic [15:0] idle_timer;
      logic        timeout_seen;
   } state_type;

   // One result transaction
   typedef struct packed {
      kind_type    out_kind;
      logic [7:0]  out_byte;
      logic [7:0]  byte_index;
      phase_type   parser_phase;
      logic        timeout_flag;
   } result_type;

endpackage

FILE: sv/lfbd_csr.sv
module lfbd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lfbd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lfbd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lfbd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output lfbd_pkg::cfg_type                   cfg
);

   // Register indexes (word address)
   localparam logic [1:0] REG_START_BYTE    = 2'd0;
   localparam logic [1:0] REG_END_BYTE      = 2'd1;
   localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

   logic [7:0]  start_byte_ff;
   logic [7:0]  end_byte_ff;
   logic [15:0] timeout_ticks_ff;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff    <= lfbd_pkg::START_BYTE_RST;
         end_byte_ff      <= lfbd_pkg::END_BYTE_RST;
         timeout_ticks_ff <= lfbd_pkg::TIMEOUT_TICKS_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_START_BYTE:    start_byte_ff    <= csr_pwdata[7:0];
            REG_END_BYTE:      end_byte_ff      <= csr_pwdata[7:0];
            REG_TIMEOUT_TICKS: timeout_ticks_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_idx)
         REG_START_BYTE:    csr_prdata = {24'd0, start_byte_ff};
         REG_END_BYTE:      csr_prdata = {24'd0, end_byte_ff};
         REG_TIMEOUT_TICKS: csr_prdata = {16'd0, timeout_ticks_ff};
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg.start_byte    = start_byte_ff;
   assign cfg.end_byte      = end_byte_ff;
   assign cfg.timeout_ticks = timeout_ticks_ff;

endmodule

FILE: sv/lfbd_step.sv
module lfbd_step (
   input  lfbd_pkg::cfg_type     cfg,
   input  lfbd_pkg::state_type   cur,
   input  lfbd_pkg::op_type      op,
   input  logic [7:0]            rx_byte,
   output lfbd_pkg::state_type   nxt,
   output lfbd_pkg::result_type  res
);

   logic [15:0] timer_inc;

   // Saturating idle count for a tick
   assign timer_inc = (cur.idle_timer == lfbd_pkg::TIMER_MAX) ? cur.idle_timer
                                                             : cur.idle_timer + 16'd1;

   always_comb begin
      nxt              = cur;
      res.out_kind     = lfbd_pkg::KIND_NONE;
      res.out_byte     = 8'd0;
      res.byte_index   = 8'd0;
      res.timeout_flag = cur.timeout_seen;

      unique case (op)
         lfbd_pkg::OP_BYTE: begin
            nxt.idle_timer = 16'd0;
            unique case (cur.phase)
               lfbd_pkg::PH_HUNT: begin
                  if (rx_byte == cfg.start_byte) nxt.phase = lfbd_pkg::PH_LEN;
               end
               lfbd_pkg::PH_LEN: begin
                  nxt.remaining = rx_byte;
                  nxt.position  = 8'd0;
                  nxt.phase     = (rx_byte != 8'd0) ? lfbd_pkg::PH_DATA : lfbd_pkg::PH_HUNT;
               end
               lfbd_pkg::PH_DATA: begin
                  res.out_kind   = lfbd_pkg::KIND_PAYLOAD;
                  res.out_byte   = rx_byte;
                  res.byte_index = cur.position;
                  nxt.position   = cur.position + 8'd1;
                  nxt.remaining  = cur.remaining - 8'd1;
                  // last payload byte when one was left
                  if (cur.remaining == 8'd1) nxt.phase = lfbd_pkg::PH_END;
               end
               lfbd_pkg::PH_END: begin
                  if (rx_byte == cfg.end_byte) begin
                     res.out_kind = lfbd_pkg::KIND_GOOD;
                  end else begin
                     res.out_kind = lfbd_pkg::KIND_BADEND;
                     res.out_byte = rx_byte;
                  end
                  nxt.phase = lfbd_pkg::PH_HUNT;
               end
               default: ;
            endcase
         end
         lfbd_pkg::OP_TICK: begin
            if (cur.phase == lfbd_pkg::PH_HUNT) begin
               nxt.idle_timer = 16'd0;
            end else if (timer_inc >= cfg.timeout_ticks) begin
               // open frame went quiet too long
               nxt.timeout_seen = 1'b1;
               nxt.phase        = lfbd_pkg::PH_HUNT;
               nxt.idle_timer   = 16'd0;
               res.out_kind     = lfbd_pkg::KIND_TIMEOUT;
            end else begin
               nxt.idle_timer = timer_inc;
            end
            res.timeout_flag = nxt.timeout_seen;
         end
         lfbd_pkg::OP_STATUS: begin
            res.out_kind     = lfbd_pkg::KIND_STATUS;
            nxt.timeout_seen = 1'b0;
         end
         lfbd_pkg::OP_RESET: begin
            nxt.phase        = lfbd_pkg::PH_HUNT;
            nxt.remaining    = 8'd0;
            nxt.position     = 8'd0;
            nxt.idle_timer   = 16'd0;
            nxt.timeout_seen = 1'b0;
            res.timeout_flag = 1'b0;
         end
         default: ;
      endcase

      res.parser_phase = nxt.phase;
   end

endmodule

FILE: sv/length_framed_byte_deframer.sv
// A result is registered: it appears in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle unless a pending result is stalled; the parser state
// and the result register both update at the accepting edge, and the result register frees
// itself in the same cycle it is taken downstream.
// Reset (synchronous, active high): parser in hunt, counters and timeout flag
// cleared, no result pending, registers back to start 126, end 127, timeout 1000.
module length_framed_byte_deframer (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_op,
   input  logic [7:0]                          req_rx_byte,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_out_kind,
   output logic [7:0]                          rsp_out_byte,
   output logic [7:0]                          rsp_byte_index,
   output logic [1:0]                          rsp_parser_phase,
   output logic                                rsp_timeout_flag,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lfbd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lfbd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lfbd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   lfbd_pkg::cfg_type    cfg;
   lfbd_pkg::state_type  state_ff;
   lfbd_pkg::state_type  state_in;
   lfbd_pkg::result_type result_ff;
   lfbd_pkg::result_type result_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 req_accept;

   lfbd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lfbd_step u_step (
      .cfg     (cfg),
      .cur     (state_ff),
      .op      (lfbd_pkg::op_type'(req_op)),
      .rx_byte (req_rx_byte),
      .nxt     (state_in),
      .res     (result_in)
   );

   // Hold off input only while a result sits unclaimed
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept)     rsp_valid_in = 1'b1;
      else if (rsp_stall) rsp_valid_in = rsp_valid_ff;
      else                rsp_valid_in = 1'b0;
   end

   // Parser state, result register and valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= lfbd_pkg::PH_HUNT;
         state_ff.remaining    <= 8'd0;
         state_ff.position     <= 8'd0;
         state_ff.idle_timer   <= 16'd0;
         state_ff.timeout_seen <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff  <= state_in;
            result_ff <= result_in;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_kind     = result_ff.out_kind;
   assign rsp_out_byte     = result_ff.out_byte;
   assign rsp_byte_index   = result_ff.byte_index;
   assign rsp_parser_phase = result_ff.parser_phase;
   assign rsp_timeout_flag = result_ff.timeout_flag;

`ifndef SYNTHESIS
   // A pending result that is stalled must block new input
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input accepted while result stalled");

   // Parser reset leaves hunt phase and a clear flag
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_op == lfbd_pkg::OP_RESET) |=>
      (rsp_valid && rsp_parser_phase == lfbd_pkg::PH_HUNT && !rsp_timeout_flag
       && state_ff.idle_timer == 16'd0))
      else $error("parser reset did not clear state");

   // Payload only comes out of data phase
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind == lfbd_pkg::KIND_PAYLOAD) |->
      (rsp_parser_phase == lfbd_pkg::PH_DATA || rsp_parser_phase == lfbd_pkg::PH_END))
      else $error("payload outside data phase");

   // Timeout abort always returns to hunt with the flag set
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind == lfbd_pkg::KIND_TIMEOUT) |->
      (rsp_parser_phase == lfbd_pkg::PH_HUNT && rsp_timeout_flag))
      else $error("timeout abort without flag or hunt");

   // Idle timer stays clear while hunting
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == lfbd_pkg::PH_HUNT) |-> (state_ff.idle_timer == 16'd0))
      else $error("idle timer running while hunting");
`endif

endmodule

FILE: verif/length_framed_byte_deframer_test.sv
module length_framed_byte_deframer_test;

   // Register byte addresses
   localparam logic [lfbd_pkg::CSR_ADDR_W-1:0] ADDR_START_BYTE = 4'd0;
   localparam logic [lfbd_pkg::CSR_ADDR_W-1:0] ADDR_END_BYTE   = 4'd4;
   localparam logic [lfbd_pkg::CSR_ADDR_W-1:0] ADDR_TIMEOUT    = 4'd8;
   localparam logic [lfbd_pkg::CSR_ADDR_W-1:0] ADDR_SPARE      = 4'd12;

   // Cycles with no transaction on either channel before the run is called hung
   localparam int QUIET_LIMIT = 5000;
   // Receiver hold-off used to back the block up
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      lfbd_pkg::op_type op;
      logic [7:0]       rx_byte;
   } rx_event_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [1:0]                      req_op = lfbd_pkg::OP_BYTE;
   logic [7:0]                      req_rx_byte = 8'd0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [2:0]                      rsp_out_kind;
   logic [7:0]                      rsp_out_byte;
   logic [7:0]                      rsp_byte_index;
   logic [1:0]                      rsp_parser_phase;
   logic                            rsp_timeout_flag;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [lfbd_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [lfbd_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [lfbd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   length_framed_byte_deframer uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow of the deframer: registers and parser state
   lfbd_pkg::cfg_type   cfg;
   lfbd_pkg::phase_type cur_phase;
   logic [7:0]          frame_left;
   logic [7:0]          frame_pos;
   logic [15:0]         idle_ticks;
   logic                timeout_sticky;

   rx_event_type         pending_events[$];
   lfbd_pkg::result_type predicted_rsp[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request = 1'b0;
   int error_count = 0;
   int events_accepted = 0;
   int settings_applied = 0;
   int kind_count[6];

   // One deframer step: updates the shadow state and returns the result it causes
   function automatic lfbd_pkg::result_type deframe_step(lfbd_pkg::op_type op,
                                                          logic [7:0] b);
      lfbd_pkg::result_type r;
      r = '0;
      r.out_kind = lfbd_pkg::KIND_NONE;
      case (op)
         lfbd_pkg::OP_BYTE: begin
            idle_ticks = '0;
            case (cur_phase)
               lfbd_pkg::PH_HUNT: begin
                  if (b == cfg.start_byte) cur_phase = lfbd_pkg::PH_LEN;
               end
               lfbd_pkg::PH_LEN: begin
                  frame_left = b;
                  frame_pos = '0;
                  cur_phase = (b != 8'd0) ? lfbd_pkg::PH_DATA : lfbd_pkg::PH_HUNT;
               end
               lfbd_pkg::PH_DATA: begin
                  r.out_kind = lfbd_pkg::KIND_PAYLOAD;
                  r.out_byte = b;
                  r.byte_index = frame_pos;
                  frame_pos = frame_pos + 8'd1;
                  frame_left = frame_left - 8'd1;
                  if (frame_left == 8'd0) cur_phase = lfbd_pkg::PH_END;
               end
               default: begin
                  if (b == cfg.end_byte) begin
                     r.out_kind = lfbd_pkg::KIND_GOOD;
                  end else begin
                     r.out_kind = lfbd_pkg::KIND_BADEND;
                     r.out_byte = b;
                  end
                  cur_phase = lfbd_pkg::PH_HUNT;
               end
            endcase
            r.timeout_flag = timeout_sticky;
         end
         lfbd_pkg::OP_TICK: begin
            if (cur_phase == lfbd_pkg::PH_HUNT) begin
               idle_ticks = '0;
            end else begin
               if (idle_ticks != lfbd_pkg::TIMER_MAX) idle_ticks = idle_ticks + 16'd1;
               // a zero timeout fires on the first tick, same as one
               if (idle_ticks >= cfg.timeout_ticks) begin
                  timeout_sticky = 1'b1;
                  cur_phase = lfbd_pkg::PH_HUNT;
                  idle_ticks = '0;
                  r.out_kind = lfbd_pkg::KIND_TIMEOUT;
               end
            end
            r.timeout_flag = timeout_sticky;
         end
         lfbd_pkg::OP_STATUS: begin
            r.out_kind = lfbd_pkg::KIND_STATUS;
            r.timeout_flag = timeout_sticky;
            timeout_sticky = 1'b0;
         end
         default: begin
            cur_phase = lfbd_pkg::PH_HUNT;
            frame_left = '0;
            frame_pos = '0;
            idle_ticks = '0;
            timeout_sticky = 1'b0;
            r.timeout_flag = 1'b0;
         end
      endcase
      r.parser_phase = cur_phase;
      return r;
   endfunction

   function automatic void queue_event(lfbd_pkg::op_type op, logic [7:0] b);
      rx_event_type ev;
      ev.op = op;
      ev.rx_byte = b;
      pending_events.push_back(ev);
   endfunction

   // Mostly well-formed frames with random content, plus noise and broken frames
   function automatic void queue_traffic(int target);
      int base;
      int pick;
      int len;
      int n;
      base = pending_events.size();
      while (pending_events.size() - base < target) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            queue_event(lfbd_pkg::OP_BYTE, cfg.start_byte);
            n = $urandom_range(99);
            if (n < 6) len = 0;
            else if (n < 8) len = 255;
            else if (n < 16) len = $urandom_range(9, 40);
            else len = $urandom_range(1, 8);
            if ($urandom_range(99) < 8) queue_event(lfbd_pkg::OP_TICK, 8'($urandom));
            queue_event(lfbd_pkg::OP_BYTE, 8'(len));
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(99) < 6) queue_event(lfbd_pkg::OP_TICK, 8'($urandom));
               queue_event(lfbd_pkg::OP_BYTE, 8'($urandom));
            end
            if (len != 0) begin
               n = $urandom_range(99);
               if (n < 6 && cfg.timeout_ticks <= 16'd64) begin
                  // let the open frame age out in the end phase
                  repeat ((cfg.timeout_ticks == 16'd0) ? 1 : int'(cfg.timeout_ticks))
                     queue_event(lfbd_pkg::OP_TICK, 8'($urandom));
               end else if (n < 88) begin
                  queue_event(lfbd_pkg::OP_BYTE, cfg.end_byte);
               end else begin
                  queue_event(lfbd_pkg::OP_BYTE, 8'($urandom));
               end
            end
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 4)) queue_event(lfbd_pkg::OP_BYTE, 8'($urandom));
         end else if (pick < 88) begin
            repeat ($urandom_range(1, 3)) queue_event(lfbd_pkg::OP_TICK, 8'($urandom));
         end else if (pick < 94) begin
            queue_event(lfbd_pkg::OP_STATUS, 8'($urandom));
         end else begin
            // frame cut short by a parser reset or a fresh start byte
            queue_event(lfbd_pkg::OP_BYTE, cfg.start_byte);
            queue_event(lfbd_pkg::OP_BYTE, 8'($urandom_range(1, 8)));
            repeat ($urandom_range(0, 2)) queue_event(lfbd_pkg::OP_BYTE, 8'($urandom));
            if ($urandom_range(1)) queue_event(lfbd_pkg::OP_RESET, 8'($urandom));
            else queue_event(lfbd_pkg::OP_BYTE, cfg.start_byte);
         end
      end
   endfunction

   task automatic check_field(string name, int unsigned want_v, int unsigned got_v);
      if (want_v != got_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
         error_count++;
      end
   endtask

   task automatic csr_write(logic [lfbd_pkg::CSR_ADDR_W-1:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      // out-of-range addresses are ignored
      case (addr)
         ADDR_START_BYTE: cfg.start_byte = data[7:0];
         ADDR_END_BYTE:   cfg.end_byte = data[7:0];
         ADDR_TIMEOUT:    cfg.timeout_ticks = data[15:0];
         default: ;
      endcase
   endtask

   task automatic csr_read(logic [lfbd_pkg::CSR_ADDR_W-1:0] addr);
      logic [31:0] want;
      case (addr)
         ADDR_START_BYTE: want = {24'd0, cfg.start_byte};
         ADDR_END_BYTE:   want = {24'd0, cfg.end_byte};
         default:         want = {16'd0, cfg.timeout_ticks};
      endcase
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("prdata", want, csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_idle(int send_pct, int recv_pct);
      @(negedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // Block is idle once nothing is queued, offered or outstanding
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_events.size() != 0 || req_valid || predicted_rsp.size() != 0);
   endtask

   // Driver: presents queued transactions, idling at random
   always @(posedge clock) begin : driver
      logic         offer;
      rx_event_type ev;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_rsp.push_back(deframe_step(lfbd_pkg::op_type'(req_op), req_rx_byte));
            events_accepted++;
         end
         if (!req_valid || !req_stall) begin
            offer = pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct;
            if (offer) begin
               ev = pending_events.pop_front();
               req_op <= ev.op;
               req_rx_byte <= ev.rx_byte;
            end
            req_valid <= offer;
         end
      end
   end

   // Monitor: checks each result against the oldest prediction, drives stall
   always @(posedge clock) begin : monitor
      lfbd_pkg::result_type want;
      bit                   hold_taken;
      int                   hold_left;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp.size() == 0) begin
               $error("unexpected result transaction, kind %0d", rsp_out_kind);
               error_count++;
            end else begin
               want = predicted_rsp.pop_front();
               kind_count[want.out_kind]++;
               check_field("out_kind", want.out_kind, rsp_out_kind);
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("byte_index", want.byte_index, rsp_byte_index);
               check_field("parser_phase", want.parser_phase, rsp_parser_phase);
               check_field("timeout_flag", want.timeout_flag, rsp_timeout_flag);
            end
         end
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= $urandom_range(99) < recv_idle_pct;
         end
      end
   end

   // Watchdog: a long stretch with no transaction means the block hung
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : sequencer
      cfg.start_byte = lfbd_pkg::START_BYTE_RST;
      cfg.end_byte = lfbd_pkg::END_BYTE_RST;
      cfg.timeout_ticks = lfbd_pkg::TIMEOUT_TICKS_RST;
      cur_phase = lfbd_pkg::PH_HUNT;
      frame_left = '0;
      frame_pos = '0;
      idle_ticks = '0;
      timeout_sticky = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset values, then a short timeout for the directed frames
      csr_read(ADDR_START_BYTE);
      csr_read(ADDR_END_BYTE);
      csr_read(ADDR_TIMEOUT);
      csr_write(ADDR_TIMEOUT, 32'd3);
      settings_applied++;
      set_idle(34, 78);

      @(negedge clock);
      queue_event(lfbd_pkg::OP_TICK, 8'h00);              // tick while hunting
      queue_event(lfbd_pkg::OP_STATUS, 8'hFF);            // flag still clear
      queue_event(lfbd_pkg::OP_BYTE, 8'h00);              // noise while hunting
      queue_event(lfbd_pkg::OP_BYTE, 8'hFF);
      queue_event(lfbd_pkg::OP_BYTE, cfg.start_byte);     // one-byte good frame
      queue_event(lfbd_pkg::OP_BYTE, 8'd1);
      queue_event(lfbd_pkg::OP_BYTE, 8'h00);
      queue_event(lfbd_pkg::OP_BYTE, cfg.end_byte);
      queue_event(lfbd_pkg::OP_BYTE, cfg.start_byte);     // two bytes, bad end byte
      queue_event(lfbd_pkg::OP_BYTE, 8'd2);
      queue_event(lfbd_pkg::OP_BYTE, 8'hFF);
      queue_event(lfbd_pkg::OP_BYTE, 8'hA5);
      queue_event(lfbd_pkg::OP_BYTE, 8'h55);
      queue_event(lfbd_pkg::OP_BYTE, cfg.start_byte);     // zero length back to hunt
      queue_event(lfbd_pkg::OP_BYTE, 8'd0);
      queue_event(lfbd_pkg::OP_BYTE, cfg.start_byte);     // frame aged out by ticks
      queue_event(lfbd_pkg::OP_BYTE, 8'd3);
      queue_event(lfbd_pkg::OP_BYTE, 8'h5A);
      repeat (3) queue_event(lfbd_pkg::OP_TICK, 8'hFF);
      queue_event(lfbd_pkg::OP_STATUS, 8'h00);            // flag set, then cleared
      queue_event(lfbd_pkg::OP_STATUS, 8'h00);
      queue_event(lfbd_pkg::OP_BYTE, cfg.start_byte);     // parser reset mid-frame
      queue_event(lfbd_pkg::OP_RESET, 8'hFF);
      queue_event(lfbd_pkg::OP_TICK, 8'h00);
      wait_drained();

      // random traffic: three idle patterns, two register settings each
      for (int mode = 0; mode < 3; mode++) begin
         if (mode == 1) set_idle(78, 34);
         else if (mode == 2) set_idle(0, 0);
         for (int s = 0; s < 2; s++) begin
            case (2 * mode + s)
               0: begin
                  csr_write(ADDR_START_BYTE, 32'd0);
                  csr_write(ADDR_END_BYTE, 32'd255);
                  csr_write(ADDR_TIMEOUT, 32'd1);
               end
               1: begin
                  csr_write(ADDR_START_BYTE, 32'd255);
                  csr_write(ADDR_END_BYTE, 32'd0);
                  csr_write(ADDR_TIMEOUT, 32'd65535);
               end
               2: begin
                  csr_write(ADDR_START_BYTE, $urandom_range(255));
                  csr_write(ADDR_END_BYTE, $urandom_range(255));
                  csr_write(ADDR_TIMEOUT, $urandom_range(2, 6));
               end
               3: begin
                  csr_write(ADDR_START_BYTE, 32'(lfbd_pkg::START_BYTE_RST));
                  csr_write(ADDR_END_BYTE, 32'(lfbd_pkg::END_BYTE_RST));
                  csr_write(ADDR_TIMEOUT, 32'd0);
               end
               default: begin
                  csr_write(ADDR_START_BYTE, $urandom);
                  csr_write(ADDR_END_BYTE, $urandom);
                  csr_write(ADDR_TIMEOUT, $urandom_range(1, 20));
               end
            endcase
            settings_applied++;
            @(negedge clock);
            queue_traffic(185);
            // no idling here: back the block up with a long receiver hold-off
            if (mode == 2 && s == 0) hold_request = 1'b1;
            wait_drained();
         end
      end

      // write to an unused address must not disturb the registers
      csr_write(ADDR_SPARE, $urandom);
      csr_read(ADDR_START_BYTE);
      csr_read(ADDR_END_BYTE);
      csr_read(ADDR_TIMEOUT);

      // largest timeout: a run of ticks leaves the open frame alive
      csr_write(ADDR_TIMEOUT, 32'd65535);
      settings_applied++;
      csr_read(ADDR_TIMEOUT);
      @(negedge clock);
      queue_event(lfbd_pkg::OP_BYTE, cfg.start_byte);
      queue_event(lfbd_pkg::OP_BYTE, 8'd5);
      queue_event(lfbd_pkg::OP_BYTE, 8'h81);
      queue_event(lfbd_pkg::OP_BYTE, 8'h7E);
      repeat (20) queue_event(lfbd_pkg::OP_TICK, 8'($urandom));
      queue_event(lfbd_pkg::OP_STATUS, 8'h00);
      repeat (3) queue_event(lfbd_pkg::OP_BYTE, 8'($urandom));
      queue_event(lfbd_pkg::OP_BYTE, cfg.end_byte);
      wait_drained();

      repeat (2) @(negedge clock);
      $display("covered %0d transactions over %0d register settings",
               events_accepted, settings_applied);
      $display("payload %0d, good %0d, bad end %0d, timeout %0d, status %0d",
               kind_count[lfbd_pkg::KIND_PAYLOAD], kind_count[lfbd_pkg::KIND_GOOD],
               kind_count[lfbd_pkg::KIND_BADEND], kind_count[lfbd_pkg::KIND_TIMEOUT],
               kind_count[lfbd_pkg::KIND_STATUS]);
      if (error_count == 0 && predicted_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/lfbd_pkg.sv
sv/lfbd_csr.sv
sv/lfbd_step.sv
sv/length_framed_byte_deframer.sv
verif/length_framed_byte_deframer_test.sv
